FILE: hw/rtl/see_pkg.sv
package see_pkg;

    typedef enum logic [2:0] {
        KIND_OPERAND = 3'd0,
        KIND_ADD     = 3'd1,
        KIND_SUB     = 3'd2,
        KIND_MUL     = 3'd3,
        KIND_DIV     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_TOOMANY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] operand_value;
        logic               last_token;
    } in_beat_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FIRST,
        S_FETCH,
        S_TOKEN,
        S_POP_A,
        S_POP_B,
        S_OP,
        S_MUL,
        S_DIV,
        S_PUSH,
        S_TOP,
        S_DONE
    } state_t;

    // request to the arithmetic unit and its answer
    typedef struct packed {
        logic        start;
        logic [2:0]  kind;
        logic [63:0] left;
        logic [63:0] right;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } alu_rsp_t;

endpackage

FILE: hw/rtl/see_alu.sv
module see_alu
    import see_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_state_t;

    alu_state_t  st_reg, st_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [1:0]  part_reg, part_next;
    logic [31:0] pa, pb;
    logic [63:0] prod;
    logic [64:0] trial;
    logic [63:0] shifted;
    logic [63:0] lneg, rneg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= A_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        part_reg <= part_next;
    end

    assign lneg = 64'd0 - req.left;
    assign rneg = 64'd0 - req.right;

    // three 32x32 partial products build the low 64 bits
    always_comb
    begin
        unique case (part_reg)
            2'd0:    begin pa = a_reg[31:0];  pb = b_reg[31:0];  end
            2'd1:    begin pa = a_reg[63:32]; pb = b_reg[31:0];  end
            default: begin pa = a_reg[31:0];  pb = b_reg[63:32]; end
        endcase
        prod = {32'd0, pa} * {32'd0, pb};
    end

    assign shifted = {rem_reg[62:0], a_reg[63]};
    assign trial   = {1'b0, shifted} - {1'b0, b_reg};

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        part_next = part_reg;
        rsp.done   = 1'b0;
        rsp.result = acc_reg;
        unique case (st_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    acc_next  = 64'd0;
                    rem_next  = 64'd0;
                    cnt_next  = 7'd0;
                    part_next = 2'd0;
                    if (req.kind == KIND_MUL)
                    begin
                        a_next  = req.left;
                        b_next  = req.right;
                        st_next = A_MUL;
                    end
                    else
                    begin
                        a_next   = req.left[63] ? lneg : req.left;
                        b_next   = req.right[63] ? rneg : req.right;
                        neg_next = req.left[63] ^ req.right[63];
                        st_next  = A_DIV;
                    end
                end
            end
            A_MUL:
            begin
                if (part_reg == 2'd0)
                begin
                    acc_next = acc_reg + prod;
                end
                else
                begin
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                end
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd2)
                begin
                    st_next = A_FIN;
                end
            end
            A_DIV:
            begin
                // one quotient bit a cycle, restoring
                if (!trial[64])
                begin
                    rem_next = trial[63:0];
                    a_next   = {a_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    a_next   = {a_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    acc_next = neg_reg ? 64'd0 - a_next : a_next;
                    st_next  = A_FIN;
                end
            end
            default:
            begin
                rsp.done = 1'b1;
                st_next  = A_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/stack_expression_evaluator.sv
// stack expression evaluator: postfix or prefix by first token
// loading: tokens load one per cycle while in_stall is low; the ALU divider is bit-serial
// throughput: one expression at a time; input stalls during evaluation and while a
//   result beat waits; an overflowed expression skips evaluation straight to its result
// reset: rst_n asynchronous active low clears control state; memories are not cleared
module stack_expression_evaluator
    import see_pkg::*;
#(
    parameter int MAX_TOKENS = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    localparam int AW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_TOKENS);

    // token buffer and operand stack: synchronous memories, one write and one read port each
    logic [66:0] tok_mem [MAX_TOKENS];
    logic [63:0] stk_mem [MAX_TOKENS];

    state_t        st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] i_reg, i_next;
    logic          ovf_reg, ovf_next;
    logic          pre_reg, pre_next;
    logic [2:0]    kind_reg, kind_next;
    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg, b_next;
    logic [63:0]   res_reg, res_next;
    logic          ov_reg, ov_next;
    out_beat_t     od_reg, od_next;

    logic          tok_we;
    logic [AW-1:0] tok_wa, tok_ra;
    logic [66:0]   tok_wd, tok_rd;
    logic          stk_we;
    logic [AW-1:0] stk_wa, stk_ra;
    logic [63:0]   stk_wd, stk_rd;

    alu_req_t areq;
    alu_rsp_t arsp;

    logic [2:0]  ck;
    logic        in_acc;
    logic        is_op;
    logic [CW-1:0] idx;

    always_ff @(posedge clk)
    begin
        if (tok_we)
        begin
            tok_mem[tok_wa] <= tok_wd;
        end
        tok_rd <= tok_mem[tok_ra];
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_rd <= stk_mem[stk_ra];
    end

    see_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_LOAD;
            cnt_reg <= '0;
            sp_reg  <= '0;
            ovf_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            sp_reg  <= sp_next;
            ovf_reg <= ovf_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        pre_reg  <= pre_next;
        kind_reg <= kind_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        res_reg  <= res_next;
        od_reg   <= od_next;
    end

    // unknown kinds fold to operand
    assign ck     = (in_data.cmd > 3'(KIND_DIV)) ? 3'(KIND_OPERAND) : in_data.cmd;
    assign in_acc = in_valid && !in_stall;
    assign is_op  = (tok_rd[66:64] != 3'(KIND_OPERAND));
    assign idx    = pre_reg ? (cnt_reg - CW'(1) - i_reg) : i_reg;

    assign in_stall  = (st_reg != S_LOAD) || (ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_LOAD:
            begin
                if (in_acc && in_data.last_token)
                begin
                    if (ovf_reg || cnt_reg == MAXC)
                    begin
                        st_next = S_DONE;
                    end
                    else
                    begin
                        st_next = S_FIRST;
                    end
                end
            end
            S_FIRST: st_next = S_FETCH;
            S_FETCH:
            begin
                if (i_reg == cnt_reg)
                begin
                    st_next = S_TOP;
                end
                else
                begin
                    st_next = S_TOKEN;
                end
            end
            S_TOKEN:
            begin
                if (!is_op)
                begin
                    st_next = S_FETCH;
                end
                else if (sp_reg < CW'(2))
                begin
                    st_next = S_DONE;
                end
                else
                begin
                    st_next = S_POP_A;
                end
            end
            S_POP_A: st_next = S_POP_B;
            S_POP_B: st_next = S_OP;
            S_OP:
            begin
                if (kind_reg == 3'(KIND_ADD) || kind_reg == 3'(KIND_SUB))
                begin
                    st_next = S_PUSH;
                end
                else if (kind_reg == 3'(KIND_MUL))
                begin
                    st_next = S_MUL;
                end
                else if ((pre_reg ? b_reg : a_reg) == 64'd0)
                begin
                    st_next = S_DONE;
                end
                else
                begin
                    st_next = S_DIV;
                end
            end
            S_MUL, S_DIV:
            begin
                if (arsp.done)
                begin
                    st_next = S_PUSH;
                end
            end
            S_PUSH: st_next = S_FETCH;
            S_TOP:  st_next = S_DONE;
            default:
            begin
                if (!ov_reg || !out_stall)
                begin
                    st_next = S_LOAD;
                end
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next  = cnt_reg;
        sp_next   = sp_reg;
        i_next    = i_reg;
        ovf_next  = ovf_reg;
        pre_next  = pre_reg;
        kind_next = kind_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        res_next  = res_reg;
        ov_next   = ov_reg;
        od_next   = od_reg;
        tok_we    = 1'b0;
        tok_wa    = cnt_reg[AW-1:0];
        tok_wd    = {ck, in_data.operand_value};
        tok_ra    = idx[AW-1:0];
        stk_we    = 1'b0;
        stk_wa    = sp_reg[AW-1:0];
        stk_wd    = res_reg;
        stk_ra    = sp_reg[AW-1:0] - AW'(1);
        areq.start = 1'b0;
        areq.kind  = kind_reg;
        areq.left  = pre_reg ? a_reg : b_reg;
        areq.right = pre_reg ? b_reg : a_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_LOAD:
            begin
                tok_ra = '0;
                if (in_acc)
                begin
                    if (cnt_reg == MAXC)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        tok_we   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (in_data.last_token)
                    begin
                        i_next = '0;
                        sp_next = '0;
                        od_next.value  = '0;
                        od_next.status = 2'(ST_TOOMANY);
                    end
                end
            end
            S_FIRST:
            begin
                // first token read from address zero
                tok_ra   = '0;
                pre_next = 1'b0;
            end
            S_FETCH:
            begin
                if (i_reg == '0)
                begin
                    pre_next = is_op;
                    tok_ra = is_op ? (cnt_reg[AW-1:0] - AW'(1)) : '0;
                end
            end
            S_TOKEN:
            begin
                kind_next = tok_rd[66:64];
                i_next    = i_reg + CW'(1);
                if (!is_op)
                begin
                    stk_we  = 1'b1;
                    stk_wd  = tok_rd[63:0];
                    sp_next = sp_reg + CW'(1);
                end
                else if (sp_reg < CW'(2))
                begin
                    od_next.value  = '0;
                    od_next.status = 2'(ST_UNDERFLOW);
                end
                else
                begin
                    stk_ra = sp_reg[AW-1:0] - AW'(1);
                end
            end
            S_POP_A:
            begin
                a_next = stk_rd;
                stk_ra = sp_reg[AW-1:0] - AW'(2);
            end
            S_POP_B:
            begin
                b_next  = stk_rd;
                sp_next = sp_reg - CW'(2);
            end
            S_OP:
            begin
                if (kind_reg == 3'(KIND_ADD))
                begin
                    res_next = a_reg + b_reg;
                end
                else if (kind_reg == 3'(KIND_SUB))
                begin
                    res_next = areq.left - areq.right;
                end
                else if (kind_reg == 3'(KIND_DIV) && areq.right == 64'd0)
                begin
                    od_next.value  = '0;
                    od_next.status = 2'(ST_DIVZERO);
                end
                else
                begin
                    areq.start = 1'b1;
                end
            end
            S_MUL, S_DIV:
            begin
                if (arsp.done)
                begin
                    res_next = arsp.result;
                end
            end
            S_PUSH:
            begin
                stk_we  = 1'b1;
                sp_next = sp_reg + CW'(1);
            end
            S_TOP:
            begin
                if (sp_reg == '0)
                begin
                    od_next.value  = '0;
                    od_next.status = 2'(ST_UNDERFLOW);
                end
                else
                begin
                    od_next.value  = stk_rd;
                    od_next.status = 2'(ST_OK);
                end
            end
            default:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next  = 1'b1;
                    cnt_next = '0;
                    sp_next  = '0;
                    ovf_next = 1'b0;
                end
            end
        endcase
        // stack top address in fetch so the top read is ready in S_TOP
        if (st_reg == S_FETCH && i_reg == cnt_reg)
        begin
            stk_ra = sp_reg[AW-1:0] - AW'(1);
        end
    end

endmodule

FILE: tb/stack_expression_evaluator_tb.sv
`timescale 1ns / 1ps

module stack_expression_evaluator_tb;
    import see_pkg::*;

    localparam int MAX_TOK     = 256;
    localparam int TOTAL_ITEMS = 900;
    localparam int CYCLE_LIMIT = 4000000;

    // scoreboard: predicts the evaluator result per expression and checks beats
    class expr_scoreboard;
        logic [2:0]  tok_kind [MAX_TOK];
        logic [63:0] tok_val [MAX_TOK];
        int          tok_count;
        bit          too_many;
        out_beat_t   pending [$];
        int          mismatches;

        function new();
            tok_count  = 0;
            too_many   = 0;
            mismatches = 0;
        endfunction

        function automatic logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
            logic [63:0] un;
            logic [63:0] ud;
            logic [63:0] q;
            un = num[63] ? -num : num;
            ud = den[63] ? -den : den;
            q  = un / ud;
            return (num[63] != den[63]) ? -q : q;
        endfunction

        function automatic out_beat_t evaluate();
            logic [63:0] stk [MAX_TOK];
            int          sp;
            int          idx;
            bit          pre;
            logic [2:0]  k;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] lhs;
            logic [63:0] rhs;
            out_beat_t   r;
            r.value  = '0;
            r.status = ST_UNDERFLOW;
            pre = tok_kind[0] inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV};
            sp  = 0;
            for (int i = 0; i < tok_count; i++)
            begin
                idx = pre ? tok_count - 1 - i : i;
                k   = tok_kind[idx];
                if (k == KIND_OPERAND)
                begin
                    stk[sp] = tok_val[idx];
                    sp++;
                end
                else
                begin
                    if (sp < 2)
                        return r;
                    a   = stk[sp-1];
                    b   = stk[sp-2];
                    sp -= 2;
                    lhs = pre ? a : b;
                    rhs = pre ? b : a;
                    case (k)
                        KIND_ADD: stk[sp] = lhs + rhs;
                        KIND_SUB: stk[sp] = lhs - rhs;
                        KIND_MUL: stk[sp] = lhs * rhs;
                        default:
                        begin
                            if (rhs == 0)
                            begin
                                r.status = ST_DIVZERO;
                                return r;
                            end
                            stk[sp] = div_trunc(lhs, rhs);
                        end
                    endcase
                    sp++;
                end
            end
            if (sp == 0)
                return r;
            r.value  = stk[sp-1];
            r.status = ST_OK;
            return r;
        endfunction

        function void note_token(in_beat_t t);
            out_beat_t r;
            logic [2:0] k;
            k = (t.cmd > KIND_DIV) ? KIND_OPERAND : t.cmd;
            if (tok_count >= MAX_TOK)
                too_many = 1;
            else
            begin
                tok_kind[tok_count] = k;
                tok_val[tok_count]  = t.operand_value;
                tok_count++;
            end
            if (t.last_token)
            begin
                if (too_many)
                begin
                    r.value  = '0;
                    r.status = ST_TOOMANY;
                end
                else
                    r = evaluate();
                pending = {pending, r};
                tok_count = 0;
                too_many  = 0;
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d status=%0d", got.value, got.status);
                return;
            end
            exp_r = pending.pop_front();
            if (got.value !== exp_r.value || got.status !== exp_r.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                             exp_r.value, exp_r.status, got.value, got.status);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;

    expr_scoreboard sb;
    int             cycles;
    int             burst_left;
    int             stall_mode;
    int             tokens_sent;

    stack_expression_evaluator #(.MAX_TOKENS(MAX_TOK)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // accepted beats on both sides go to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_token(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // receiver stall pattern: alternates between free flow, random and long holds
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // drive one token; gaps come between random-length bursts
    task automatic send_token(logic [2:0] kind, logic [63:0] v, bit last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                in_data  <= in_beat_t'(68'({$urandom, $urandom, $urandom}));
                repeat (gap)
                    @(posedge clk);
            end
        end
        burst_left--;
        tokens_sent++;
        in_valid              <= 1'b1;
        in_data.cmd           <= kind;
        in_data.operand_value <= v;
        in_data.last_token    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if ($urandom_range(0, 5) == 0)
            burst_left = 0;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 64'sh8000_0000_0000_0000;
            1:       return 64'sh7fff_ffff_ffff_ffff;
            2:       return 64'(signed'($urandom_range(0, 6)) - 3);
            3:       return {$urandom, $urandom};
            default: return 64'(signed'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        return 3'($urandom_range(KIND_ADD, KIND_DIV));
    endfunction

    // well-formed postfix of n operands, operators mixed in randomly
    task automatic send_postfix(int n);
        int depth;
        int ops_left;
        depth    = 0;
        ops_left = n - 1;
        for (int i = 0; i < n; i++)
        begin
            send_token(KIND_OPERAND, rand_value(), (n == 1));
            depth++;
            while (depth >= 2 && ops_left > 0 && (i == n - 1 || $urandom_range(0, 1)))
            begin
                ops_left--;
                depth--;
                send_token(rand_op(), rand_value(), (ops_left == 0 && i == n - 1));
            end
        end
    endtask

    // prefix: operator then two sub-expressions, built recursively
    task automatic send_prefix(int n, bit last);
        int left_n;
        if (n == 1)
            send_token(KIND_OPERAND, rand_value(), last);
        else
        begin
            left_n = $urandom_range(1, n - 1);
            send_token(rand_op(), rand_value(), 1'b0);
            send_prefix(left_n, 1'b0);
            send_prefix(n - left_n, last);
        end
    endtask

    // arbitrary token string, often malformed
    task automatic send_noise(int n);
        for (int i = 0; i < n; i++)
            send_token(3'($urandom_range(0, 7)), rand_value(), (i == n - 1));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    int sel;

    initial
    begin
        sb          = new();
        cycles      = 0;
        burst_left  = 0;
        stall_mode  = 0;
        tokens_sent = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each operator in postfix, extremes, special cases
        send_token(KIND_OPERAND, 64'sd7, 1'b0);
        send_token(KIND_OPERAND, 64'sd3, 1'b0);
        send_token(KIND_SUB, '0, 1'b1);
        send_token(KIND_DIV, '0, 1'b0);              // prefix: / -7 2
        send_token(KIND_OPERAND, -64'sd7, 1'b0);
        send_token(KIND_OPERAND, 64'sd2, 1'b1);
        // most negative divided by minus one
        send_token(KIND_OPERAND, 64'sh8000_0000_0000_0000, 1'b0);
        send_token(KIND_OPERAND, '1, 1'b0);
        send_token(KIND_DIV, '1, 1'b1);
        // max times max, then plus one
        send_token(KIND_OPERAND, 64'sh7fff_ffff_ffff_ffff, 1'b0);
        send_token(KIND_OPERAND, 64'sh7fff_ffff_ffff_ffff, 1'b0);
        send_token(KIND_MUL, '0, 1'b0);
        send_token(KIND_OPERAND, 64'sd1, 1'b0);
        send_token(KIND_ADD, '0, 1'b1);
        // divide by zero
        send_token(KIND_OPERAND, 64'sd5, 1'b0);
        send_token(KIND_OPERAND, 64'sd0, 1'b0);
        send_token(KIND_DIV, '0, 1'b1);
        // underflow: lone operator
        send_token(KIND_ADD, '0, 1'b1);
        // unknown kinds count as operands, leftover entries ignored
        send_token(3'd5, 64'sd11, 1'b0);
        send_token(3'd7, 64'sd12, 1'b1);
        send_token(3'd6, 64'sh8000_0000_0000_0000, 1'b1);
        wait_drained();

        // too many tokens: one beyond the buffer, including the last beat
        for (int i = 0; i <= MAX_TOK; i++)
            send_token(KIND_OPERAND, 64'(i), (i == MAX_TOK));
        // exactly full buffer evaluates normally
        for (int i = 0; i < MAX_TOK; i++)
            send_token((i > 0 && i % 2 == 0) ? KIND_ADD : KIND_OPERAND,
                       64'(i), (i == MAX_TOK - 1));
        wait_drained();

        // random: mostly well-formed expressions, some noise
        while (tokens_sent < TOTAL_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                send_postfix($urandom_range(1, 6));
            else if (sel < 8)
                send_prefix($urandom_range(1, 6), 1'b1);
            else
                send_noise($urandom_range(1, 8));
            if ($urandom_range(0, 40) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/see_pkg.sv
hw/rtl/see_alu.sv
hw/rtl/stack_expression_evaluator.sv
tb/stack_expression_evaluator_tb.sv
